@@ rtl/core/cara_pkg.sv @@
// ---------------------------------------------------------------------------
// cara_pkg: shared types and constants of the row evolver
// Holds the controller state type, status codes and config indexes.
// ---------------------------------------------------------------------------
package cara_pkg;

    localparam int unsigned RuleW = 32;
    localparam int unsigned GenW  = 40;
    localparam int unsigned SumW  = 64;
    localparam int unsigned StW   = 2;
    localparam int unsigned CfgW  = 40;

    localparam logic [StW-1:0] ST_OK       = 2'd0;
    localparam logic [StW-1:0] ST_RULE0    = 2'd1;
    localparam logic [StW-1:0] ST_OVERFLOW = 2'd2;

    localparam logic CFG_RULE = 1'b0;
    localparam logic CFG_GENS = 1'b1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_GEN,
        S_CMP,
        S_MUL,
        S_COPY,
        S_SUM,
        S_OUT
    } t_state;

endpackage

@@ rtl/core/cara_ram.sv @@
// ---------------------------------------------------------------------------
// cara_ram: generic single-port-write, single-read RAM
// One write and one registered read each cycle.
// ---------------------------------------------------------------------------
module cara_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/cellular_automaton_row_evolver.sv @@
// ---------------------------------------------------------------------------
// cellular_automaton_row_evolver: radius-2 binary cellular automaton
// Loads a row one cell per request, evolves it, returns the live-cell sum.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// s_axis   in   s_axis_tvalid/tready   tdata[0]=cell_req, tlast=last_cell
// m_axis   out  m_axis_tvalid/tready   tdata[63:0]=live_sum, tuser[1:0]=status
// cfg      in   i_cfg_we               i_cfg_index, i_cfg_data
//
// Cells load at one per cycle while no result waits. After the last cell, each
// generation scans the row, compares the new row with the old one and copies
// the new row back. A translated row instead folds the remaining shift into
// the origin with a shift-add product, one multiplier bit at a time. A final
// pass sums, and the S_OUT state loads the result into the output register.
// Each phase reads its row memory through that memory's single read port.
// Reset clears control state only; row memories hold no reset value.
// A result waits in the output register; the next row does not load until
// it is taken.
module cellular_automaton_row_evolver
    import cara_pkg::*;
#(
    parameter int unsigned MAX_CELLS = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // [0] cell_req
    input  logic            s_axis_tlast,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [SumW-1:0] m_axis_tdata,   // [63:0] live_sum
    output logic [StW-1:0]  m_axis_tuser,   // [1:0] status
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [CfgW-1:0] i_cfg_data
);
    localparam int unsigned AW = $clog2(MAX_CELLS);
    localparam int unsigned LW = AW + 1;
    localparam int unsigned CW = LW + 1;   // scan counter up to len+4 and beyond

    t_state r_state, n_state;
    logic [RuleW-1:0] r_rule;
    logic [GenW-1:0]  r_gens, r_gcnt;
    logic [LW-1:0]    r_len;
    logic [SumW-1:0]  r_org, r_shift, r_sum;
    logic             r_ovf;
    logic [CW-1:0]    r_j;          // scan index (read address issued)
    logic             r_rv;         // a read was issued last cycle
    logic [CW-1:0]    r_jd;         // index of that read
    logic [4:0]       r_win;
    logic             r_found;
    logic [LW:0]      r_pos, r_nlen;
    logic             r_diff;
    logic [SumW-1:0]  r_mcand;      // shifted multiplicand of the shift product
    logic [GenW-1:0]  r_mrem;       // multiplier bits not yet applied
    logic [SumW-1:0]  r_res;
    logic [StW-1:0]   r_st;
    logic             r_ov;

    logic          cur_we, nxt_we, cur_q, nxt_q, cur_wd;
    logic [AW-1:0] cur_wa, cur_ra, nxt_wa, nxt_ra;
    logic          bit_in, v, gen_ovf, load_ovf, scan_last, rd_ok, scan_done, same_row;
    logic [4:0]    win_n;

    cara_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_cur (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(cur_wa), .i_wdata(cur_wd),
        .i_raddr(cur_ra), .o_rdata(cur_q));
    cara_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(v),
        .i_raddr(nxt_ra), .o_rdata(nxt_q));

    logic s_acc, m_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_LOAD) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_res;
    assign m_axis_tuser  = r_st;

    // A cell past capacity, including the final one, makes the load overflow.
    assign load_ovf = r_ovf || (r_len >= LW'(MAX_CELLS));

    // Generation scan datapath: window built from the cell read last cycle.
    assign bit_in = r_rv && (r_jd < CW'(r_len)) ? cur_q : 1'b0;
    assign win_n  = {r_win[3:0], bit_in};
    assign v      = r_rule[win_n];

    // A live cell at a position past capacity ends evolution at once.
    assign gen_ovf = r_rv && v && (r_pos >= (LW+1)'(MAX_CELLS));

    // read for index len+3 is the final neighbourhood
    assign scan_last = r_rv && (r_jd == CW'(r_len) + CW'(3));

    // Phases with counter r_j:
    // S_GEN : read cur[j]; emit into nxt.
    // S_CMP : read cur[j], nxt[j] compared at r_jd.
    // S_COPY: read nxt[j], write cur at r_jd.
    // S_SUM : read cur[j], accumulate.
    assign rd_ok     = (r_j < CW'(r_len));
    assign scan_done = !rd_ok && !r_rv;
    assign same_row  = (r_nlen == (LW+1)'(r_len)) && !r_diff;
    assign cur_ra = r_j[AW-1:0];
    assign nxt_ra = r_j[AW-1:0];

    always_comb begin
        cur_we = 1'b0;
        cur_wa = r_len[AW-1:0];
        cur_wd = s_axis_tdata[0];
        nxt_we = 1'b0;
        nxt_wa = r_pos[AW-1:0];
        case (r_state)
            S_LOAD: begin
                cur_we = s_acc && (r_len < LW'(MAX_CELLS));
            end
            S_GEN: begin
                nxt_we = r_rv && (r_found || v) && (r_pos < (LW+1)'(MAX_CELLS));
            end
            S_COPY: begin
                cur_we = r_rv;
                cur_wa = r_jd[AW-1:0];
                cur_wd = nxt_q;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (s_acc && s_axis_tlast) begin
                    if (r_rule[0] || load_ovf) begin
                        n_state = S_OUT;
                    end else if (r_gens != '0) begin
                        n_state = S_GEN;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_GEN: begin
                if (gen_ovf) begin
                    n_state = S_OUT;
                end else if (scan_last) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (scan_done) begin
                    n_state = same_row ? S_MUL : S_COPY;
                end
            end
            S_MUL: begin
                if (r_mrem == '0) begin
                    n_state = S_SUM;
                end
            end
            S_COPY: begin
                // The copy ends a generation; once the count is reached, sum.
                if (scan_done) begin
                    n_state = (r_gcnt >= r_gens) ? S_SUM : S_GEN;
                end
            end
            S_SUM: begin
                if (scan_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // The sequencer's datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rule  <= '0;
            r_gens  <= GenW'(20);
            r_len   <= '0;
            r_org   <= '0;
            r_gcnt  <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
            r_rv    <= 1'b0;
            r_j     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RULE) begin
                    r_rule <= i_cfg_data[RuleW-1:0];
                end else begin
                    r_gens <= i_cfg_data[GenW-1:0];
                end
            end
            if (m_acc) begin
                r_ov <= 1'b0;
            end
            r_state <= n_state;
            r_rv    <= 1'b0;
            r_jd    <= r_j;
            case (r_state)
                S_LOAD: begin
                    if (s_acc) begin
                        if (r_len < LW'(MAX_CELLS)) begin
                            r_len <= r_len + LW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    r_j <= '0; r_win <= '0; r_found <= 1'b0; r_pos <= '0;
                    r_nlen <= '0; r_shift <= '1 - SumW'(1); r_diff <= 1'b0;
                    r_sum <= '0;
                    if (s_acc && s_axis_tlast) begin
                        r_st <= r_rule[0] ? ST_RULE0 : (load_ovf ? ST_OVERFLOW : ST_OK);
                    end
                end
                S_GEN: begin
                    if (r_j <= CW'(r_len) + CW'(3)) begin
                        r_rv <= 1'b1;
                        r_j  <= r_j + CW'(1);
                    end
                    if (r_rv) begin
                        r_win <= win_n;
                        if (!r_found && !v) begin
                            r_shift <= r_shift + SumW'(1);
                        end else begin
                            r_found <= 1'b1;
                            if (v) begin
                                if (gen_ovf) begin
                                    r_st  <= ST_OVERFLOW;
                                    r_sum <= '0;
                                end
                                r_nlen <= r_pos + (LW+1)'(1);
                            end
                            r_pos <= r_pos + (LW+1)'(1);
                        end
                    end
                    if (scan_last) begin
                        r_j <= '0;
                        r_rv <= 1'b0;
                    end
                end
                S_CMP: begin
                    if (rd_ok) begin
                        r_rv <= 1'b1;
                        r_j  <= r_j + CW'(1);
                    end
                    if (r_rv && (cur_q != nxt_q)) begin
                        r_diff <= 1'b1;
                    end
                    if (scan_done) begin
                        r_j <= '0;
                        if (same_row) begin
                            // Remaining generations each add the same shift.
                            r_mcand <= r_shift;
                            r_mrem  <= r_gens - r_gcnt;
                            r_gcnt  <= r_gens;
                        end else begin
                            r_org  <= r_org + r_shift;
                            r_gcnt <= r_gcnt + GenW'(1);
                        end
                        r_len <= r_nlen[LW-1:0];
                    end
                end
                S_MUL: begin
                    // One multiplier bit per cycle; the product wraps at 64 bits.
                    if (r_mrem != '0) begin
                        if (r_mrem[0]) begin
                            r_org <= r_org + r_mcand;
                        end
                        r_mcand <= r_mcand << 1;
                        r_mrem  <= r_mrem >> 1;
                    end
                end
                S_COPY: begin
                    if (rd_ok) begin
                        r_rv <= 1'b1;
                        r_j  <= r_j + CW'(1);
                    end
                    if (scan_done) begin
                        r_j <= '0; r_win <= '0; r_found <= 1'b0; r_pos <= '0;
                        r_nlen <= '0; r_shift <= '1 - SumW'(1); r_diff <= 1'b0;
                    end
                end
                S_SUM: begin
                    if (rd_ok) begin
                        r_rv <= 1'b1;
                        r_j  <= r_j + CW'(1);
                    end
                    if (r_rv && cur_q) begin
                        r_sum <= r_sum + r_org + SumW'(r_jd);
                    end
                end
                S_OUT: begin
                    r_res <= r_sum;
                    r_ov  <= 1'b1;
                    r_len <= '0; r_org <= '0; r_gcnt <= '0; r_ovf <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("load while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> m_axis_tvalid)
        else $error("result not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len <= LW'(MAX_CELLS)))
        else $error("row length beyond capacity");
endmodule

@@ verif/cellular_automaton_row_evolver_test.sv @@
// ---------------------------------------------------------------------------
// Self-checking bench for the radius-2 cellular automaton row evolver
// Streams rows of cells into the block, predicts each live-cell sum and status
// from an internal model of the evolution, and compares every returned result.
// ---------------------------------------------------------------------------
module cellular_automaton_row_evolver_test;
    import cara_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROW_CAP = 1024;
    localparam longint unsigned GEN_MASK = 64'hFF_FFFF_FFFF;
    localparam logic [GenW-1:0] GENS_MAX = '1;

    // Rules that only copy or translate a row, so evolution ends once the trimmed
    // row repeats, within two generations, no matter how many are configured.
    localparam logic [RuleW-1:0] RULE_COPY    = 32'hF0F0_F0F0;
    localparam logic [RuleW-1:0] RULE_RIGHT1  = 32'hFF00_FF00;
    localparam logic [RuleW-1:0] RULE_RIGHT2  = 32'hFFFF_0000;
    localparam logic [RuleW-1:0] RULE_LEFT1   = 32'hCCCC_CCCC;
    localparam logic [RuleW-1:0] RULE_LEFT2   = 32'hAAAA_AAAA;
    // Every non-empty neighbourhood gives a live cell: the row grows by four
    // cells per generation.
    localparam logic [RuleW-1:0] RULE_GROW    = 32'hFFFF_FFFE;

    typedef struct packed {
        logic alive;
        logic last;
    } cell_req_t;

    typedef struct packed {
        logic [SumW-1:0] live_sum;
        logic [StW-1:0]  status;
    } row_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;  // [0] cell_req
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SumW-1:0]       m_axis_tdata;       // [63:0] live_sum
    logic [StW-1:0]        m_axis_tuser;       // [1:0] status
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = CFG_RULE;
    logic [CfgW-1:0]       i_cfg_data = '0;

    cellular_automaton_row_evolver #(
        .MAX_CELLS(ROW_CAP)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Requests not yet offered, and sums predicted but not yet returned.
    cell_req_t   cells_waiting[$];
    row_result_t sums_due[$];
    bit          failed = 1'b0;
    bit          no_gaps = 1'b0;   // when set, sender and receiver insert no random gaps

    // -----------------------------------------------------------------------
    // Predictor state: a private copy of the registers and of the row.
    // -----------------------------------------------------------------------
    logic [RuleW-1:0] cfg_rule = '0;
    logic [GenW-1:0]  cfg_gens = 40'd20;
    bit               row_cur[ROW_CAP];
    bit               row_nxt[ROW_CAP];
    int unsigned      row_len = 0;
    longint unsigned  row_origin = 0;
    longint unsigned  gen_done = 0;
    bit               load_spill = 1'b0;

    // One generation. Returns 0 when evolution goes on, 1 when the row only
    // translated (the rest of the translation is folded into the origin at
    // once), and 2 when the trimmed row would not fit.
    function automatic int evolve_generation();
        int unsigned     win, pos, new_len, j;
        bit              s, v, found, same;
        longint unsigned shift;
        win = 0;
        shift = 64'hFFFF_FFFF_FFFF_FFFE;
        found = 1'b0;
        pos = 0;
        new_len = 0;
        for (j = 0; j < row_len + 4; j++) begin
            s = (j < row_len) ? row_cur[j] : 1'b0;
            win = ((win << 1) | s) & 32'd31;
            v = cfg_rule[win];
            // Leading dead cells move the origin instead of being stored.
            if (!found) begin
                if (!v) begin
                    shift++;
                    continue;
                end
                found = 1'b1;
            end
            if (v) begin
                if (pos >= ROW_CAP) return 2;
                new_len = pos + 1;
            end
            if (pos < ROW_CAP) row_nxt[pos] = v;
            pos++;
        end
        if (new_len == row_len) begin
            same = 1'b1;
            for (j = 0; j < row_len; j++)
                if (row_cur[j] != row_nxt[j]) same = 1'b0;
            if (same) begin
                row_origin += shift * ((64'(cfg_gens) - gen_done) & GEN_MASK);
                return 1;
            end
        end
        for (j = 0; j < new_len; j++) row_cur[j] = row_nxt[j];
        row_len = new_len;
        row_origin += shift;
        return 0;
    endfunction

    // Takes one accepted request; the final cell of a row yields a result.
    function automatic void absorb_cell(bit alive, bit last);
        row_result_t res;
        int          r;
        if (row_len < ROW_CAP) begin
            row_cur[row_len] = alive;
            row_len++;
        end else begin
            load_spill = 1'b1;
        end
        if (!last) return;
        res.live_sum = '0;
        res.status = ST_OK;
        if (cfg_rule[0]) begin
            res.status = ST_RULE0;
        end else if (load_spill) begin
            res.status = ST_OVERFLOW;
        end else begin
            for (gen_done = 0; gen_done < 64'(cfg_gens); gen_done++) begin
                r = evolve_generation();
                if (r == 1) break;
                if (r == 2) begin
                    res.status = ST_OVERFLOW;
                    break;
                end
            end
            if (res.status == ST_OK)
                for (int unsigned i = 0; i < row_len; i++)
                    if (row_cur[i]) res.live_sum += row_origin + 64'(i);
        end
        sums_due = {sums_due, res};
        row_len = 0;
        row_origin = 0;
        gen_done = 0;
        load_spill = 1'b0;
    endfunction

    // -----------------------------------------------------------------------
    // Sender: offers queued cells with a random gap after each request.
    // -----------------------------------------------------------------------
    int unsigned src_gap = 0;

    always @(posedge i_clk) begin
        cell_req_t item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_cell(s_axis_tdata[0], s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (cells_waiting.size() != 0) begin
                    item = cells_waiting.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {7'd0, item.alive};
                    s_axis_tlast <= item.last;
                    src_gap <= no_gaps ? 0 : $urandom_range(0, 7);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: checks each result against the oldest prediction. After the
    // tenth result it holds tready low for a long stretch so that the block
    // keeps its result waiting and stops taking cells from the sender.
    // -----------------------------------------------------------------------
    int unsigned sink_wait = 0;
    int unsigned results_seen = 0;

    always @(posedge i_clk) begin
        row_result_t exp_res;
        int unsigned next_wait;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait <= 0;
        end else begin
            next_wait = (sink_wait != 0) ? sink_wait - 1 : 0;
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (sums_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual sum %0d status %0d",
                             $time, $signed(m_axis_tdata), m_axis_tuser);
                    failed = 1'b1;
                end else begin
                    exp_res = sums_due.pop_front();
                    if (m_axis_tdata !== exp_res.live_sum) begin
                        $display("%0t: live_sum: expected %0d, actual %0d", $time,
                                 $signed(exp_res.live_sum), $signed(m_axis_tdata));
                        failed = 1'b1;
                    end
                    if (m_axis_tuser !== exp_res.status) begin
                        $display("%0t: status: expected %0d, actual %0d", $time,
                                 exp_res.status, m_axis_tuser);
                        failed = 1'b1;
                    end
                end
                if (results_seen == 10) next_wait = 600;
                else next_wait = no_gaps ? 0 : $urandom_range(0, 7);
            end
            sink_wait <= next_wait;
            m_axis_tready <= (next_wait == 0);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus.
    // -----------------------------------------------------------------------

    // Pattern 0 gives random cells, 1 all dead cells, 2 all live cells.
    task automatic queue_row(int unsigned n, int pattern);
        cell_req_t item;
        for (int unsigned i = 0; i < n; i++) begin
            case (pattern)
                1: item.alive = 1'b0;
                2: item.alive = 1'b1;
                default: item.alive = 1'($urandom_range(0, 1));
            endcase
            item.last = (i == n - 1);
            cells_waiting = {cells_waiting, item};
        end
    endtask

    // Registers change only once the block has returned every result. The
    // check runs on the falling edge, after all clocked updates have settled.
    task automatic wait_idle();
        while (cells_waiting.size() != 0 || s_axis_tvalid || sums_due.size() != 0)
            @(negedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CfgW-1:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RULE) cfg_rule = value[RuleW-1:0];
        else cfg_gens = value[GenW-1:0];
        @(posedge i_clk);
    endtask

    function automatic logic [RuleW-1:0] pick_translator();
        case ($urandom_range(0, 4))
            0: return RULE_COPY;
            1: return RULE_RIGHT1;
            2: return RULE_RIGHT2;
            3: return RULE_LEFT1;
            default: return RULE_LEFT2;
        endcase
    endfunction

    initial begin
        int unsigned     random_cells;
        int unsigned     len;
        logic [GenW-1:0] gens;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: a rule of all zeros kills every row.
        queue_row(5, 2);
        queue_row(1, 1);

        // Translating rules with the largest generation count: the remaining
        // shift is applied at once, and the left-moving rule wraps the sum.
        write_reg(CFG_GENS, GENS_MAX);
        write_reg(CFG_RULE, CfgW'(RULE_RIGHT1));
        queue_row(6, 0);
        write_reg(CFG_RULE, CfgW'(RULE_LEFT2));
        queue_row(4, 2);
        write_reg(CFG_RULE, CfgW'(RULE_COPY));
        queue_row(3, 0);
        queue_row(2, 1);

        // Empty neighbourhood alive: no evolution at all.
        write_reg(CFG_RULE, CfgW'(32'hFFFF_FFFF));
        queue_row(3, 0);

        // Zero generations: the loaded row is summed as it stands.
        write_reg(CFG_RULE, CfgW'(32'h1234_5678));
        write_reg(CFG_GENS, '0);
        queue_row(5, 0);

        // A single live cell grows until the row passes capacity.
        write_reg(CFG_RULE, CfgW'(RULE_GROW));
        write_reg(CFG_GENS, 40'd300);
        queue_row(1, 2);

        // More cells loaded than the row holds.
        queue_row(ROW_CAP + 2, 0);

        // Random part: phases of register settings, each with several rows.
        random_cells = 0;
        while (random_cells < 250) begin
            wait_idle();
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0: begin
                    write_reg(CFG_RULE, CfgW'($urandom | 32'd1));
                    gens = GenW'($urandom_range(0, 30));
                end
                1, 2: begin
                    write_reg(CFG_RULE, CfgW'(pick_translator()));
                    gens = GenW'({$urandom, $urandom});
                end
                default: begin
                    write_reg(CFG_RULE, CfgW'($urandom & ~32'd1));
                    gens = GenW'($urandom_range(0, 24));
                end
            endcase
            write_reg(CFG_GENS, gens);
            repeat ($urandom_range(4, 8)) begin
                len = $urandom_range(1, 48);
                queue_row(len, 0);
                random_cells += len;
            end
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (!failed) begin
            $display("cellular_automaton_row_evolver: match");
        end else begin
            $display("cellular_automaton_row_evolver: mismatch");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("cellular_automaton_row_evolver: mismatch");
        $finish;
    end

endmodule
